// ----- hdl/ecc_pkg.sv -----
// ecc_pkg: shared types, codes and helpers of the elevator cab controller
// no dependencies; imported by every module in hdl/

package ecc_pkg;

  // field widths
  localparam int unsigned WeightW = 24;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned FloorW  = 2;
  localparam int unsigned SensW   = 3;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned CfgIdxW = 2;

  // reset values of the configuration registers
  localparam logic [WeightW-1:0] TareRst     = 24'd9020400;
  localparam logic [WeightW-1:0] OvlOnRst    = 24'd12350;
  localparam logic [WeightW-1:0] OvlOffRst   = 24'd11050;
  localparam logic [PeriodW-1:0] RefreshRst  = 16'd200;
  localparam logic [FloorW-1:0]  FloorRst    = 2'd1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARE        = 2'd0,
    CFG_OVL_ON      = 2'd1,
    CFG_OVL_OFF     = 2'd2,
    CFG_REFRESH     = 2'd3
  } cfg_reg_e;

  // external mode codes
  localparam logic [CodeW-1:0] CodeWaitKey   = 3'd0;
  localparam logic [CodeW-1:0] CodeWaitReq   = 3'd1;
  localparam logic [CodeW-1:0] CodeMoving    = 3'd2;
  localparam logic [CodeW-1:0] CodeOverload  = 3'd3;
  localparam logic [CodeW-1:0] CodeEmergency = 3'd4;

  // controller states, one-hot
  typedef enum logic [4:0] {
    MODE_WAIT_KEY  = 5'b00001,
    MODE_WAIT_REQ  = 5'b00010,
    MODE_MOVING    = 5'b00100,
    MODE_OVERLOAD  = 5'b01000,
    MODE_EMERGENCY = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [WeightW-1:0] tare;
    logic [WeightW-1:0] ovl_on;
    logic [WeightW-1:0] ovl_off;
    logic [PeriodW-1:0] refresh_period;
  } cfg_t;

  typedef struct packed {
    logic [SensW-1:0]   floor_sensors;
    logic [WeightW-1:0] raw_weight;
    logic               card_read;
    logic               floor_request;
    logic [FloorW-1:0]  target_floor;
    logic               emergency_button;
    logic               bypass_switch;
    logic               silence_switch;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0]  mode_code;
    logic [FloorW-1:0] present_floor;
    logic              motor_up;
    logic              motor_down;
    logic              motor_enable;
    logic              buzzer_level;
    logic [SensW-1:0]  floor_leds;
    logic              display_refresh;
    logic              technician_call;
  } result_t;

  // state to external code
  function automatic logic [CodeW-1:0] mode_to_code(mode_e m);
    logic [CodeW-1:0] c;
    c = CodeWaitKey;
    unique case (m)
      MODE_WAIT_KEY:  c = CodeWaitKey;
      MODE_WAIT_REQ:  c = CodeWaitReq;
      MODE_MOVING:    c = CodeMoving;
      MODE_OVERLOAD:  c = CodeOverload;
      MODE_EMERGENCY: c = CodeEmergency;
      default:        c = CodeWaitKey;
    endcase
    return c;
  endfunction

  // one-hot led of a floor number
  function automatic logic [SensW-1:0] floor_to_leds(logic [FloorW-1:0] f);
    logic [SensW-1:0] l;
    l = '0;
    case (f)
      2'd1:    l = 3'b001;
      2'd2:    l = 3'b010;
      2'd3:    l = 3'b100;
      default: l = 3'b000;
    endcase
    return l;
  endfunction

endpackage

// ----- hdl/ecc_cfg_regs.sv -----
// ecc_cfg_regs: configuration register file of the cab controller
// depends on ecc_pkg

module ecc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ecc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ecc_pkg::WeightW-1:0]   cfg_data_i,
  output ecc_pkg::cfg_t                 cfg_o
);
  import ecc_pkg::*;

  cfg_t cfg_q;

  // indexed write, all indexes map to a register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tare           <= TareRst;
      cfg_q.ovl_on         <= OvlOnRst;
      cfg_q.ovl_off        <= OvlOffRst;
      cfg_q.refresh_period <= RefreshRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TARE:    cfg_q.tare           <= cfg_data_i;
        CFG_OVL_ON:  cfg_q.ovl_on         <= cfg_data_i;
        CFG_OVL_OFF: cfg_q.ovl_off        <= cfg_data_i;
        CFG_REFRESH: cfg_q.refresh_period <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/ecc_in_reg.sv -----
// ecc_in_reg: input register stage holding one tick word
// depends on ecc_pkg

module ecc_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ecc_pkg::item_t item_i,
  input  logic          take_i,
  output logic          item_valid_o,
  output ecc_pkg::item_t item_o
);
  import ecc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // full and not drained this cycle holds the input side
  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- hdl/ecc_core.sv -----
// ecc_core: controller state, per-tick next-state logic and result register
// depends on ecc_pkg

module ecc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ecc_pkg::cfg_t   cfg_i,
  input  logic            item_valid_i,
  input  ecc_pkg::item_t  item_i,
  output logic            take_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ecc_pkg::result_t result_o
);
  import ecc_pkg::*;

  localparam int unsigned NetW = WeightW + 2;

  // controller state
  mode_e              mode_q, mode_d;
  logic [FloorW-1:0]  floor_q, floor_d;
  logic               card_q, card_d;
  logic               req_q, req_d;
  logic               up_q, up_d;
  logic               down_q, down_d;
  logic               en_q, en_d;
  logic               buzz_q, buzz_d;
  logic [PeriodW-1:0] rcnt_q, rcnt_d;
  logic               out_valid_q;
  result_t            res_q, res_d;

  logic signed [NetW-1:0] net;
  logic                   over_on, over_off;
  logic                   tech, refresh;
  logic [PeriodW-1:0]     rcnt_inc;

  // result slot free or being drained
  assign take_o = item_valid_i & (~out_valid_q | ~out_stall_i);

  // net weight and hysteresis compares
  assign net = $signed({2'b00, item_i.raw_weight}) - $signed({2'b00, cfg_i.tare});
  assign over_on  = net > $signed({2'b00, cfg_i.ovl_on});
  assign over_off = net < $signed({2'b00, cfg_i.ovl_off});

  assign rcnt_inc = rcnt_q + 1'b1;

  // one tick of the controller
  always_comb begin
    mode_d  = mode_q;
    floor_d = floor_q;
    up_d    = up_q;
    down_d  = down_q;
    en_d    = en_q;
    tech    = 1'b0;
    refresh = 1'b0;

    // lowest closed sensor wins
    if (item_i.floor_sensors[0]) begin
      floor_d = 2'd1;
    end else if (item_i.floor_sensors[1]) begin
      floor_d = 2'd2;
    end else if (item_i.floor_sensors[2]) begin
      floor_d = 2'd3;
    end

    card_d = card_q | item_i.card_read;
    req_d  = req_q | item_i.floor_request;

    if (over_on) begin
      mode_d = MODE_OVERLOAD;
    end

    // priority chain: emergency, release, overload, overload clear
    if (item_i.emergency_button) begin
      if (mode_d != MODE_EMERGENCY) begin
        mode_d = MODE_EMERGENCY;
        up_d   = 1'b0;
        down_d = 1'b0;
        en_d   = 1'b0;
        tech   = 1'b1;
      end
    end else if (mode_d == MODE_EMERGENCY) begin
      mode_d = MODE_WAIT_KEY;
    end else if (over_on) begin
      mode_d = MODE_OVERLOAD;
    end else if (mode_d == MODE_OVERLOAD && over_off) begin
      mode_d = MODE_WAIT_KEY;
    end

    // state action
    unique case (mode_d)
      MODE_WAIT_KEY: begin
        if (card_d || item_i.bypass_switch) begin
          card_d = 1'b0;
          mode_d = MODE_WAIT_REQ;
        end
      end
      MODE_WAIT_REQ: begin
        if (req_d) begin
          req_d  = 1'b0;
          mode_d = MODE_MOVING;
        end
      end
      MODE_MOVING: begin
        if (item_i.target_floor > floor_d) begin
          up_d   = 1'b1;
          down_d = 1'b0;
        end else if (item_i.target_floor < floor_d) begin
          up_d   = 1'b0;
          down_d = 1'b1;
        end
        en_d = 1'b1;
        if (item_i.target_floor == floor_d) begin
          up_d   = 1'b0;
          down_d = 1'b0;
          en_d   = 1'b0;
          req_d  = 1'b0;
          mode_d = MODE_WAIT_KEY;
        end
      end
      default: begin
        up_d   = 1'b0;
        down_d = 1'b0;
        en_d   = 1'b0;
      end
    endcase

    // buzzer toggles during an unsilenced alarm
    if ((mode_d == MODE_OVERLOAD || mode_d == MODE_EMERGENCY) && !item_i.silence_switch) begin
      buzz_d = ~buzz_q;
    end else begin
      buzz_d = 1'b0;
    end

    // display refresh divider
    rcnt_d = rcnt_inc;
    if (rcnt_inc >= cfg_i.refresh_period) begin
      refresh = 1'b1;
      rcnt_d  = '0;
    end
  end

  // result word
  always_comb begin
    res_d.mode_code       = mode_to_code(mode_d);
    res_d.present_floor   = floor_d;
    res_d.motor_up        = up_d;
    res_d.motor_down      = down_d;
    res_d.motor_enable    = en_d;
    res_d.buzzer_level    = buzz_d;
    res_d.floor_leds      = floor_to_leds(floor_d);
    res_d.display_refresh = refresh;
    res_d.technician_call = tech;
  end

  // state registers advance once per taken word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_WAIT_KEY;
      floor_q <= FloorRst;
      card_q  <= 1'b0;
      req_q   <= 1'b0;
      up_q    <= 1'b0;
      down_q  <= 1'b0;
      en_q    <= 1'b0;
      buzz_q  <= 1'b0;
      rcnt_q  <= '0;
    end else if (take_o) begin
      mode_q  <= mode_d;
      floor_q <= floor_d;
      card_q  <= card_d;
      req_q   <= req_d;
      up_q    <= up_d;
      down_q  <= down_d;
      en_q    <= en_d;
      buzz_q  <= buzz_d;
      rcnt_q  <= rcnt_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // motor bridge never driven both ways
  a_bridge_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(up_q && down_q))
    else $error("motor drive up and down at once");

  // motor enabled only while moving
  a_enable_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_q |-> (mode_q == MODE_MOVING))
    else $error("motor enabled outside moving");

  // technician call only reported together with emergency mode
  a_tech_emergency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.technician_call) |-> (res_q.mode_code == CodeEmergency))
    else $error("technician call without emergency");

  // a taken word always leaves a result ready on the next cycle
  a_take_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> out_valid_q)
    else $error("taken word left no result");

endmodule

// ----- hdl/elevator_cab_controller.sv -----
// elevator_cab_controller: top level of the elevator cab controller
// depends on ecc_pkg, ecc_cfg_regs, ecc_in_reg, ecc_core
//
//  channel   handshake              payload
//  -------   --------------------   -------------------------------------------
//  input     in_valid_i/in_stall_o  floor_sensors_i .. silence_switch_i
//  result    out_valid_o/out_stall_i mode_code_o .. technician_call_o
//  config    cfg_we_i               cfg_idx_i, cfg_data_i
//
// one word a cycle sustained while out_stall_i is low; a word passes through the input
// register and then the result register.
// the tick logic between the two registers sets the clock period.
// reset clears the controller state and both valid flags; config returns to defaults.
// a stalled result holds; the input register keeps taking words while the result
// register is free or drained in the same cycle.

module elevator_cab_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ecc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ecc_pkg::WeightW-1:0]   cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ecc_pkg::SensW-1:0]     floor_sensors_i,
  input  logic [ecc_pkg::WeightW-1:0]   raw_weight_i,
  input  logic                          card_read_i,
  input  logic                          floor_request_i,
  input  logic [ecc_pkg::FloorW-1:0]    target_floor_i,
  input  logic                          emergency_button_i,
  input  logic                          bypass_switch_i,
  input  logic                          silence_switch_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ecc_pkg::CodeW-1:0]     mode_code_o,
  output logic [ecc_pkg::FloorW-1:0]    present_floor_o,
  output logic                          motor_up_o,
  output logic                          motor_down_o,
  output logic                          motor_enable_o,
  output logic                          buzzer_level_o,
  output logic [ecc_pkg::SensW-1:0]     floor_leds_o,
  output logic                          display_refresh_o,
  output logic                          technician_call_o
);
  import ecc_pkg::*;

  cfg_t    cfg;
  item_t   item_in, item;
  logic    item_valid, take;
  result_t res;

  // gather the input word
  always_comb begin
    item_in.floor_sensors    = floor_sensors_i;
    item_in.raw_weight       = raw_weight_i;
    item_in.card_read        = card_read_i;
    item_in.floor_request    = floor_request_i;
    item_in.target_floor     = target_floor_i;
    item_in.emergency_button = emergency_button_i;
    item_in.bypass_switch    = bypass_switch_i;
    item_in.silence_switch   = silence_switch_i;
  end

  ecc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ecc_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item_in),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ecc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (res)
  );

  // split the result word onto its ports
  assign mode_code_o       = res.mode_code;
  assign present_floor_o   = res.present_floor;
  assign motor_up_o        = res.motor_up;
  assign motor_down_o      = res.motor_down;
  assign motor_enable_o    = res.motor_enable;
  assign buzzer_level_o    = res.buzzer_level;
  assign floor_leds_o      = res.floor_leds;
  assign display_refresh_o = res.display_refresh;
  assign technician_call_o = res.technician_call;

endmodule
